### rtl/tsbc_pkg.sv
// shared types and constants for the triangle setup and cull block
`default_nettype none
package tsbc_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int DIV_NUM_W   = 28;
	localparam int DIV_DEN_W   = 14;

	localparam logic [1:0] CFG_WIDTH       = 2'd0;
	localparam logic [1:0] CFG_HEIGHT      = 2'd1;
	localparam logic [1:0] CFG_SUPERSAMPLE = 2'd2;

	localparam logic [1:0] CULL_CCW = 2'd1;
	localparam logic [1:0] CULL_CW  = 2'd2;

	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [31:0] z;
		logic        [31:0] color;
		logic        [31:0] u;
		logic        [31:0] v;
	} vtx_t;

	typedef struct packed {
		vtx_t [3:0] vtx;
		logic       quad;
		logic [1:0] cull;
	} prim_t;

	typedef struct packed {
		logic [12:0] width;
		logic [12:0] height;
		logic        ss;
	} cfg_t;

endpackage
`default_nettype wire

### rtl/triangle_setup_backface_cull_top.sv
// top level of the triangle setup and back-face cull block
`default_nettype none
// Vertices are gathered one per transaction into a four-entry store; the
// last vertex of a primitive of three or four vertices queues the whole
// primitive and the gathering side goes on taking vertices while the queue
// has room. The setup side runs the winding test of each triangle through
// the difference, multiply and compare states, then maps each emitted vertex
// with the two one-bit-a-cycle dividers that scale x and y by the screen
// size (28 steps), between a start state and the output load.
// Configuration is always ready and should be written only while idle.
module triangle_setup_backface_cull_top
	import tsbc_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] pos_x_in,
	input  wire logic signed [15:0] pos_y_in,
	input  wire logic signed [31:0] depth_in,
	input  wire logic        [31:0] argb,
	input  wire logic        [31:0] tex_u,
	input  wire logic        [31:0] tex_v,
	input  wire logic        [1:0]  cull_mode,
	input  wire logic               vertex_last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      ndc_x,
	output logic signed [15:0]      ndc_y,
	output logic        [15:0]      depth_out,
	output logic        [7:0]       red,
	output logic        [7:0]       green,
	output logic        [7:0]       blue,
	output logic        [7:0]       alpha,
	output logic        [31:0]      tex_u_out,
	output logic        [31:0]      tex_v_out,
	output logic                    run_last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic        [1:0]  cfg_index,
	input  wire logic        [12:0] cfg_data
);

	cfg_t  cfg_q;
	logic  q_push, q_full, q_pop, q_empty;
	prim_t q_in, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RESET;
			cfg_q.height <= HEIGHT_RESET;
			cfg_q.ss     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:       cfg_q.width  <= cfg_data;
				CFG_HEIGHT:      cfg_q.height <= cfg_data;
				CFG_SUPERSAMPLE: cfg_q.ss     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tsbc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pos_x_in    (pos_x_in),
		.pos_y_in    (pos_y_in),
		.depth_in    (depth_in),
		.argb        (argb),
		.tex_u       (tex_u),
		.tex_v       (tex_v),
		.cull_mode   (cull_mode),
		.vertex_last (vertex_last),
		.push        (q_push),
		.push_data   (q_in),
		.full        (q_full)
	);

	tsbc_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	tsbc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (~q_empty),
		.q_data    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ndc_x     (ndc_x),
		.ndc_y     (ndc_y),
		.depth_out (depth_out),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha     (alpha),
		.tex_u_out (tex_u_out),
		.tex_v_out (tex_v_out),
		.run_last  (run_last)
	);

	// primitive queue never overruns or underruns
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("primitive pushed into full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(q_pop && q_empty))
		else $error("primitive popped from empty queue");
	// a stalled result holds until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
			out_valid && out_stall |=> out_valid && $stable(ndc_x) && $stable(run_last))
		else $error("stalled result changed");

endmodule
`default_nettype wire

### rtl/tsbc_front.sv
// vertex gathering: stores up to four vertices and queues complete primitives
`default_nettype none
module tsbc_front
	import tsbc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] pos_x_in,
	input  wire logic signed [15:0] pos_y_in,
	input  wire logic signed [31:0] depth_in,
	input  wire logic        [31:0] argb,
	input  wire logic        [31:0] tex_u,
	input  wire logic        [31:0] tex_v,
	input  wire logic        [1:0]  cull_mode,
	input  wire logic               vertex_last,
	output logic                    push,
	output prim_t                   push_data,
	input  wire logic               full
);

	logic [2:0] cnt_q;
	logic [2:0] cnt_next;
	vtx_t [3:0] store_q;
	vtx_t [3:0] merged;
	vtx_t       vin;
	logic       accept;

	assign in_stall = full;
	assign accept   = in_valid & ~full;

	always_comb begin
		vin.x     = pos_x_in;
		vin.y     = pos_y_in;
		vin.z     = depth_in;
		vin.color = argb;
		vin.u     = tex_u;
		vin.v     = tex_v;
		merged    = store_q;
		cnt_next  = cnt_q;
		// vertices past the fourth are dropped
		if (cnt_q < 3'd4) begin
			merged[cnt_q[1:0]] = vin;
			cnt_next           = cnt_q + 3'd1;
		end
	end

	assign push = accept & vertex_last & (cnt_next == 3'd3 || cnt_next == 3'd4);

	always_comb begin
		push_data.vtx  = merged;
		push_data.quad = (cnt_next == 3'd4);
		push_data.cull = cull_mode;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (accept) begin
			cnt_q <= vertex_last ? 3'd0 : cnt_next;
		end
	end

endmodule
`default_nettype wire

### rtl/tsbc_queue.sv
// short primitive queue between gathering and setup
`default_nettype none
module tsbc_queue
	import tsbc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire prim_t push_data,
	output logic       full,
	input  wire logic  pop,
	output prim_t      head,
	output logic       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	prim_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/tsbc_div.sv
// unsigned restoring divider, one quotient bit per cycle
`default_nettype none
module tsbc_div
	import tsbc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_NUM_W-1:0] num,
	input  wire logic [DIV_DEN_W-1:0] den,
	output logic                      done,
	output logic      [DIV_NUM_W-1:0] quo
);

	localparam int CW = $clog2(DIV_NUM_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/tsbc_back.sv
// triangle setup: winding test, vertex mapping and output register
`default_nettype none
module tsbc_back
	import tsbc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	input  wire logic         q_valid,
	input  wire prim_t        q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic signed [15:0] ndc_x,
	output logic signed [15:0] ndc_y,
	output logic        [15:0] depth_out,
	output logic        [7:0]  red,
	output logic        [7:0]  green,
	output logic        [7:0]  blue,
	output logic        [7:0]  alpha,
	output logic        [31:0] tex_u_out,
	output logic        [31:0] tex_v_out,
	output logic               run_last
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DIFF   = 7'b0000010,
		ST_MUL    = 7'b0000100,
		ST_CMP    = 7'b0001000,
		ST_VSTART = 7'b0010000,
		ST_WAIT   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic       tri_q;
	logic [1:0] vk_q;
	logic [1:0] keep_q;

	logic signed [16:0] e1_s1, e2_s1, e3_s1, e4_s1;
	logic signed [33:0] p1_s2, p2_s2;
	logic signed [34:0] area;
	logic               culled;
	logic               keep0, keep1;

	vtx_t va, vb, vc, vs;
	logic [1:0] idx;

	logic [12:0]          dw, dh;
	logic [DIV_DEN_W-1:0] den_x, den_y;
	logic signed [DIV_NUM_W:0] nx, ny;
	logic [DIV_NUM_W-1:0] mag_x, mag_y;
	logic                 div_start;
	logic                 done_x, done_y;
	logic [DIV_NUM_W-1:0] quo_x, quo_y;
	logic                 neg_x_q, neg_y_q;
	logic [15:0]          depth_q;
	logic [15:0]          depth_v;
	logic [33:0]          zprod;
	logic                 load;
	logic                 last_v;

	function automatic logic [DIV_NUM_W-1:0] floor_mag(input logic signed [DIV_NUM_W:0] n,
			input logic [DIV_DEN_W-1:0] den);
		logic signed [DIV_NUM_W:0] t;
		t = -n + $signed({{(DIV_NUM_W + 1 - DIV_DEN_W){1'b0}}, den}) - (DIV_NUM_W + 1)'(1);
		return n[DIV_NUM_W] ? t[DIV_NUM_W-1:0] : n[DIV_NUM_W-1:0];
	endfunction

	function automatic logic [15:0] to_ndc(input logic [DIV_NUM_W-1:0] q, input logic neg);
		logic signed [DIV_NUM_W+1:0] s;
		s = $signed({2'b00, q});
		if (neg) begin
			s = -s;
		end
		s = s - (DIV_NUM_W + 2)'(16384);
		if (s > (DIV_NUM_W + 2)'(32767)) begin
			return 16'h7fff;
		end else if (s < -(DIV_NUM_W + 2)'(32768)) begin
			return 16'h8000;
		end
		return s[15:0];
	endfunction

	// triangle 0-1-2 or 0-2-3
	always_comb begin
		va = q_data.vtx[0];
		vb = tri_q ? q_data.vtx[2] : q_data.vtx[1];
		vc = tri_q ? q_data.vtx[3] : q_data.vtx[2];
	end

	assign area = 35'(p1_s2) - 35'(p2_s2);

	always_comb begin
		case (q_data.cull)
			CULL_CCW: culled = area[34];
			CULL_CW:  culled = ~area[34] & (area != '0);
			default:  culled = 1'b0;
		endcase
	end

	assign keep0 = tri_q ? keep_q[0] : ~culled;
	assign keep1 = tri_q ? ~culled : 1'b0;

	always_comb begin
		if (!tri_q) begin
			idx = vk_q;
		end else begin
			idx = (vk_q == 2'd0) ? 2'd0 : vk_q + 2'd1;
		end
		vs = q_data.vtx[idx];
	end

	// zero size counts as one, the divisor is twice the size
	assign dw    = (cfg.width == '0) ? 13'd1 : cfg.width;
	assign dh    = (cfg.height == '0) ? 13'd1 : cfg.height;
	assign den_x = {dw, 1'b0};
	assign den_y = {dh, 1'b0};

	always_comb begin
		nx = cfg.ss ? ((DIV_NUM_W + 1)'(vs.x) <<< 11) : ((DIV_NUM_W + 1)'(vs.x) <<< 12);
		nx = nx + $signed({{(DIV_NUM_W - 12){1'b0}}, dw});
		ny = ((DIV_NUM_W + 1)'(vs.y) <<< 12) + $signed({{(DIV_NUM_W - 12){1'b0}}, dh});
		mag_x = floor_mag(nx, den_x);
		mag_y = floor_mag(ny, den_y);
	end

	assign zprod = vs.z[17:0] * 16'hffff;

	always_comb begin
		if (vs.z[31] || vs.z == '0) begin
			depth_v = 16'd0;
		end else if (vs.z >= 32'sd262144) begin
			depth_v = 16'hffff;
		end else begin
			depth_v = 16'((zprod + 34'd131072) >> 18);
		end
	end

	assign div_start = (state_q == ST_VSTART);

	tsbc_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag_x),
		.den    (den_x),
		.done   (done_x),
		.quo    (quo_x)
	);

	tsbc_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag_y),
		.den    (den_y),
		.done   (done_y),
		.quo    (quo_y)
	);

	assign load   = (state_q == ST_EMIT) & (~out_valid | ~out_stall);
	assign last_v = (vk_q == 2'd2) & (tri_q | ~keep_q[1]);

	always_comb begin
		q_pop = 1'b0;
		if (load && last_v) begin
			q_pop = 1'b1;
		end
		if (state_q == ST_CMP && !(tri_q == 1'b0 && q_data.quad) && !keep0 && !keep1) begin
			q_pop = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			e1_s1 <= 17'(vb.x) - 17'(va.x);
			e2_s1 <= 17'(vc.y) - 17'(va.y);
			e3_s1 <= 17'(vb.y) - 17'(va.y);
			e4_s1 <= 17'(vc.x) - 17'(va.x);
		end
		if (state_q == ST_MUL) begin
			p1_s2 <= e1_s1 * e2_s1;
			p2_s2 <= e3_s1 * e4_s1;
		end
		if (state_q == ST_VSTART) begin
			neg_x_q <= nx[DIV_NUM_W];
			neg_y_q <= ny[DIV_NUM_W];
			depth_q <= depth_v;
		end
		if (load) begin
			ndc_x     <= to_ndc(quo_x, neg_x_q);
			ndc_y     <= to_ndc(quo_y, neg_y_q);
			depth_out <= depth_q;
			alpha     <= vs.color[31:24];
			red       <= vs.color[23:16];
			green     <= vs.color[15:8];
			blue      <= vs.color[7:0];
			tex_u_out <= vs.u;
			tex_v_out <= vs.v;
			run_last  <= last_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tri_q     <= 1'b0;
			vk_q      <= 2'd0;
			keep_q    <= 2'b00;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						tri_q   <= 1'b0;
						keep_q  <= 2'b00;
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_CMP;
				ST_CMP: begin
					keep_q[tri_q] <= ~culled;
					vk_q          <= 2'd0;
					if (!tri_q && q_data.quad) begin
						tri_q   <= 1'b1;
						state_q <= ST_DIFF;
					end else if (keep0) begin
						tri_q   <= 1'b0;
						state_q <= ST_VSTART;
					end else if (keep1) begin
						tri_q   <= 1'b1;
						state_q <= ST_VSTART;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_VSTART: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (done_x && done_y) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						if (vk_q != 2'd2) begin
							vk_q    <= vk_q + 2'd1;
							state_q <= ST_VSTART;
						end else if (!tri_q && keep_q[1]) begin
							tri_q   <= 1'b1;
							vk_q    <= 2'd0;
							state_q <= ST_VSTART;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
